// ===== rtl/core/lla_pkg.sv =====
// Shared constants, codes and types of the life-like automaton generation block.
`timescale 1ns / 1ps

package lla_pkg;

  // Grid geometry.
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);

  // Field and register widths.
  localparam int CNT_W   = 7;
  localparam int MASK_W  = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_A_W = 2;
  localparam int GEN_W   = 32;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_BIRTH_MASK   = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_SURVIVE_MASK = 2'd3;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef logic [MAX_COLUMNS-1:0] grid_row_t;

  // One read and one write request to the row-organized grid store.
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    grid_row_t        wr_data;
  } grid_req_t;

endpackage

// ===== rtl/core/life_like_automaton_generation_top.sv =====
// Top level of the life-like automaton generation block: sequencer, registers and ports.
// An advance sweeps one cell per cycle through the single rule unit; per row it also reads
// the next row from the grid store and writes the new row back. A write or read outside
// the area in use, or one with the unused code, goes to the result without the grid store.
// One item is in work at a time; a finished result waits in the output register.
// Reset kills every cell through per-row valid bits at once, with no clearing pass.
`timescale 1ns / 1ps

module life_like_automaton_generation_top
  import lla_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [5:0]         column_i,
  input  logic [5:0]         row_i,
  input  logic               cell_in_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               cell_value_o,
  output logic [GEN_W-1:0]   generation_count_o
);

  // Sequencer states. A write reads the row, patches one bit and writes it back. An advance
  // first loads the last row and row 0, then for each row fetches the row below, sweeps the
  // columns through the rule unit and writes the new row.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_MOD,
    ST_RD_GET,
    ST_ADV_LOAD0,
    ST_ADV_LOAD1,
    ST_ADV_FETCH,
    ST_ADV_CELL,
    ST_ADV_WB,
    ST_DONE
  } state_e;

  localparam logic [CNT_W-1:0] ColsMax = CNT_W'(MAX_COLUMNS);
  localparam logic [CNT_W-1:0] RowsMax = CNT_W'(MAX_ROWS);

  // Configuration registers.
  logic [CNT_W-1:0]  col_cnt_q;
  logic [CNT_W-1:0]  row_cnt_q;
  logic [MASK_W-1:0] birth_mask_q;
  logic [MASK_W-1:0] survive_mask_q;

  // Sequencer and datapath registers.
  state_e            state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              cell_in_q, cell_in_d;
  logic [COL_W-1:0]  sweep_col_q, sweep_col_d;
  grid_row_t         prev_q, prev_d;
  grid_row_t         cur_q, cur_d;
  grid_row_t         nxt_q, nxt_d;
  grid_row_t         row0_q, row0_d;
  grid_row_t         new_q, new_d;
  logic              nxt_wrap_q, nxt_wrap_d;
  logic              res_cell_q, res_cell_d;
  logic [GEN_W-1:0]  gen_q, gen_d;
  logic              out_valid_q, out_valid_d;
  logic              out_cell_q, out_cell_d;
  logic [GEN_W-1:0]  out_gen_q, out_gen_d;

  logic [COL_W-1:0]  cols_last;
  logic [ROW_W-1:0]  rows_last;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic              in_inside;
  logic              in_accept;
  grid_req_t         grid_req;
  grid_row_t         grid_rd_data;
  logic              rule_cell;

  // The count registers act as 1 when zero and saturate at the grid size; the sequencer
  // works with the index of the last column and row in use.
  always_comb begin
    if (col_cnt_q == '0) begin
      cols_last = '0;
    end else if (col_cnt_q > ColsMax) begin
      cols_last = COL_W'(MAX_COLUMNS - 1);
    end else begin
      cols_last = COL_W'(col_cnt_q - CNT_W'(1));
    end
    if (row_cnt_q == '0) begin
      rows_last = '0;
    end else if (row_cnt_q > RowsMax) begin
      rows_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_W'(row_cnt_q - CNT_W'(1));
    end
  end

  assign in_col    = COL_W'(column_i);
  assign in_row    = ROW_W'(row_i);
  assign in_inside = (in_col <= cols_last) && (in_row <= rows_last);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  lla_grid u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (grid_req),
    .rd_data_o (grid_rd_data)
  );

  // The rule unit sees the three original rows around the row being swept.
  lla_rule u_rule (
    .row_above_i    (prev_q),
    .row_mid_i      (cur_q),
    .row_below_i    (nxt_q),
    .col_i          (sweep_col_q),
    .col_last_i     (cols_last),
    .birth_mask_i   (birth_mask_q),
    .survive_mask_i (survive_mask_q),
    .cell_o         (rule_cell)
  );

  always_comb begin
    logic [ROW_W-1:0] row_inc;
    grid_row_t        patched;

    row_inc     = row_q + ROW_W'(1);
    patched     = grid_rd_data;
    patched[col_q] = cell_in_q;

    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    cell_in_d   = cell_in_q;
    sweep_col_d = sweep_col_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    row0_d      = row0_q;
    new_d       = new_q;
    nxt_wrap_d  = nxt_wrap_q;
    res_cell_d  = res_cell_q;
    gen_d       = gen_q;
    out_cell_d  = out_cell_q;
    out_gen_d   = out_gen_q;
    out_valid_d = out_valid_q && !out_ready_i;

    grid_req         = '0;
    grid_req.wr_addr = row_q;
    grid_req.wr_data = new_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          row_d      = in_row;
          col_d      = in_col;
          cell_in_d  = cell_in_i;
          res_cell_d = 1'b0;
          case (func_e'(func_i))
            FUNC_WRITE: begin
              if (in_inside) begin
                grid_req.rd_en   = 1'b1;
                grid_req.rd_addr = in_row;
                state_d          = ST_WR_MOD;
              end else begin
                state_d = ST_DONE;
              end
            end
            FUNC_READ: begin
              if (in_inside) begin
                grid_req.rd_en   = 1'b1;
                grid_req.rd_addr = in_row;
                state_d          = ST_RD_GET;
              end else begin
                state_d = ST_DONE;
              end
            end
            FUNC_ADVANCE: begin
              // The last row is the upper neighbor of row 0.
              grid_req.rd_en   = 1'b1;
              grid_req.rd_addr = rows_last;
              state_d          = ST_ADV_LOAD0;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_WR_MOD: begin
        grid_req.wr_en   = 1'b1;
        grid_req.wr_data = patched;
        state_d          = ST_DONE;
      end
      ST_RD_GET: begin
        res_cell_d = grid_rd_data[col_q];
        state_d    = ST_DONE;
      end
      ST_ADV_LOAD0: begin
        prev_d           = grid_rd_data;
        grid_req.rd_en   = 1'b1;
        grid_req.rd_addr = '0;
        state_d          = ST_ADV_LOAD1;
      end
      ST_ADV_LOAD1: begin
        // Row 0 is kept, since it is overwritten before the last row needs it.
        cur_d            = grid_rd_data;
        row0_d           = grid_rd_data;
        row_d            = '0;
        nxt_wrap_d       = (rows_last == '0);
        grid_req.rd_en   = (rows_last != '0);
        grid_req.rd_addr = ROW_W'(1);
        state_d          = ST_ADV_FETCH;
      end
      ST_ADV_FETCH: begin
        nxt_d       = nxt_wrap_q ? row0_q : grid_rd_data;
        new_d       = cur_q;
        sweep_col_d = '0;
        state_d     = ST_ADV_CELL;
      end
      ST_ADV_CELL: begin
        new_d[sweep_col_q] = rule_cell;
        if (sweep_col_q == cols_last) begin
          state_d = ST_ADV_WB;
        end else begin
          sweep_col_d = sweep_col_q + COL_W'(1);
        end
      end
      ST_ADV_WB: begin
        grid_req.wr_en = 1'b1;
        prev_d         = cur_q;
        cur_d          = nxt_q;
        if (row_q == rows_last) begin
          gen_d   = gen_q + GEN_W'(1);
          state_d = ST_DONE;
        end else begin
          // Fetch the row below the next one; below the last row lies the saved row 0.
          row_d            = row_inc;
          nxt_wrap_d       = (row_inc == rows_last);
          grid_req.rd_en   = (row_inc != rows_last);
          grid_req.rd_addr = row_inc + ROW_W'(1);
          state_d          = ST_ADV_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_cell_d  = res_cell_q;
          out_gen_d   = gen_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      gen_q          <= '0;
      out_valid_q    <= 1'b0;
      col_cnt_q      <= CNT_W'(64);
      row_cnt_q      <= CNT_W'(64);
      birth_mask_q   <= MASK_W'(8);
      survive_mask_q <= MASK_W'(12);
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMN_COUNT: col_cnt_q      <= cfg_data_i[CNT_W-1:0];
          CFG_ROW_COUNT:    row_cnt_q      <= cfg_data_i[CNT_W-1:0];
          CFG_BIRTH_MASK:   birth_mask_q   <= cfg_data_i[MASK_W-1:0];
          CFG_SURVIVE_MASK: survive_mask_q <= cfg_data_i[MASK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    cell_in_q   <= cell_in_d;
    sweep_col_q <= sweep_col_d;
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    nxt_q       <= nxt_d;
    row0_q      <= row0_d;
    new_q       <= new_d;
    nxt_wrap_q  <= nxt_wrap_d;
    res_cell_q  <= res_cell_d;
    out_cell_q  <= out_cell_d;
    out_gen_q   <= out_gen_d;
  end

  assign out_valid_o        = out_valid_q;
  assign cell_value_o       = out_cell_q;
  assign generation_count_o = out_gen_q;

endmodule

// ===== rtl/core/lla_grid.sv =====
// Row-organized cell grid store with per-row valid bits.
`timescale 1ns / 1ps

module lla_grid
  import lla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  grid_req_t req_i,
  output grid_row_t rd_data_o
);

  grid_row_t             mem [MAX_ROWS];
  grid_row_t             rd_data_q;
  logic [MAX_ROWS-1:0]   row_valid_q;
  logic                  rd_valid_q;

  // A row that was never written reads as all dead cells.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_addr];
      end
      if (req_i.wr_en) begin
        row_valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/lla_rule.sv =====
// Shared neighbor counter and birth/survive rule unit for one cell.
`timescale 1ns / 1ps

module lla_rule
  import lla_pkg::*;
(
  input  grid_row_t         row_above_i,
  input  grid_row_t         row_mid_i,
  input  grid_row_t         row_below_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [COL_W-1:0]  col_last_i,
  input  logic [MASK_W-1:0] birth_mask_i,
  input  logic [MASK_W-1:0] survive_mask_i,
  output logic              cell_o
);

  logic [COL_W-1:0]  col_left;
  logic [COL_W-1:0]  col_right;
  logic [7:0]        nbr;
  logic [3:0]        nbr_cnt;
  logic [MASK_W-1:0] mask;

  // Neighbor columns wrap around the edges of the area in use.
  assign col_left  = (col_i == '0) ? col_last_i : col_i - COL_W'(1);
  assign col_right = (col_i == col_last_i) ? '0 : col_i + COL_W'(1);

  assign nbr = {row_above_i[col_left], row_above_i[col_i], row_above_i[col_right],
                row_mid_i[col_left], row_mid_i[col_right],
                row_below_i[col_left], row_below_i[col_i], row_below_i[col_right]};

  always_comb begin
    nbr_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      nbr_cnt = nbr_cnt + {3'b000, nbr[i]};
    end
  end

  assign mask   = row_mid_i[col_i] ? survive_mask_i : birth_mask_i;
  assign cell_o = mask[nbr_cnt];

endmodule

// ===== tb/sv/life_like_automaton_generation_checker.sv =====
// Checker for the life-like automaton block: predicts every result and compares it.
`timescale 1ns / 1ps

module life_like_automaton_generation_checker
  import lla_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,

  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         func_i,
  input  logic [5:0]         column_i,
  input  logic [5:0]         row_i,
  input  logic               cell_in_i,

  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               cell_value_i,
  input  logic [GEN_W-1:0]   generation_count_i,

  output int                 mismatch_count_o,
  output int                 pending_count_o
);

  typedef struct packed {
    logic             cell_value;
    logic [GEN_W-1:0] generation_count;
  } cell_result_t;

  // Shadow copy of the grid, indexed [row][column], and of the registers.
  bit                cells_q [MAX_ROWS][MAX_COLUMNS];
  logic [GEN_W-1:0]  generation_q;
  logic [CNT_W-1:0]  column_count_q;
  logic [CNT_W-1:0]  row_count_q;
  logic [MASK_W-1:0] birth_mask_q;
  logic [MASK_W-1:0] survive_mask_q;

  cell_result_t awaited_results_q [$];
  int           mismatches;

  function automatic int effective_count(logic [CNT_W-1:0] raw, int max_count);
    if (raw == '0) return 1;
    if (raw > max_count) return max_count;
    return int'(raw);
  endfunction

  // One generation over the area in use; the torus wraps at the area edges, so on
  // narrow grids several neighbor positions may hit the same cell.
  function automatic void advance_generation();
    bit next_cells [MAX_ROWS][MAX_COLUMNS];
    int cols;
    int rows;
    int row_at [3];
    int col_at [3];
    int live;
    cols = effective_count(column_count_q, MAX_COLUMNS);
    rows = effective_count(row_count_q, MAX_ROWS);
    for (int r = 0; r < rows; r++) begin
      row_at = '{(r == 0) ? rows - 1 : r - 1, r, (r + 1 == rows) ? 0 : r + 1};
      for (int c = 0; c < cols; c++) begin
        col_at = '{(c == 0) ? cols - 1 : c - 1, c, (c + 1 == cols) ? 0 : c + 1};
        live = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (i != 1 || j != 1) live += cells_q[row_at[i]][col_at[j]];
          end
        end
        next_cells[r][c] = cells_q[r][c] ? survive_mask_q[live] : birth_mask_q[live];
      end
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) cells_q[r][c] = next_cells[r][c];
    end
    generation_q = generation_q + 1'b1;
  endfunction

  function automatic cell_result_t apply_cell_op(func_e op, logic [5:0] col, logic [5:0] row,
                                                 logic value);
    cell_result_t res;
    logic         in_area;
    in_area = (col < effective_count(column_count_q, MAX_COLUMNS)) &&
              (row < effective_count(row_count_q, MAX_ROWS));
    res.cell_value = 1'b0;
    case (op)
      FUNC_WRITE: begin
        if (in_area) cells_q[row][col] = value;
      end
      FUNC_ADVANCE: begin
        advance_generation();
      end
      FUNC_READ: begin
        if (in_area) res.cell_value = cells_q[row][col];
      end
      default: begin
      end
    endcase
    res.generation_count = generation_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t want;
    if (!rst_ni) begin
      foreach (cells_q[r, c]) cells_q[r][c] = 1'b0;
      generation_q     = '0;
      column_count_q   = CNT_W'(MAX_COLUMNS);
      row_count_q      = CNT_W'(MAX_ROWS);
      birth_mask_q     = MASK_W'(8);
      survive_mask_q   = MASK_W'(12);
      awaited_results_q.delete();
      mismatches       = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMN_COUNT: column_count_q = cfg_data_i[CNT_W-1:0];
          CFG_ROW_COUNT:    row_count_q    = cfg_data_i[CNT_W-1:0];
          CFG_BIRTH_MASK:   birth_mask_q   = cfg_data_i[MASK_W-1:0];
          CFG_SURVIVE_MASK: survive_mask_q = cfg_data_i[MASK_W-1:0];
          default: begin
          end
        endcase
      end

      // Results are checked before this edge's new transaction is predicted.
      if (out_valid_i && out_ready_i) begin
        if (awaited_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result: cell_value %0d, generation_count %0d",
                     cell_value_i, generation_count_i);
          end
        end else begin
          want = awaited_results_q.pop_front();
          if (cell_value_i !== want.cell_value) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cell_value mismatch: expected %0d, got %0d",
                       want.cell_value, cell_value_i);
            end
          end
          if (generation_count_i !== want.generation_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("generation_count mismatch: expected %0d, got %0d",
                       want.generation_count, generation_count_i);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        awaited_results_q.push_back(apply_cell_op(func_e'(func_i), column_i, row_i, cell_in_i));
      end

      mismatch_count_o <= mismatches;
      pending_count_o  <= awaited_results_q.size();
    end
  end

endmodule

// ===== tb/sv/life_like_automaton_generation_top_tb.sv =====
// Testbench top for the life-like automaton block: stimulus, pacing and final verdict.
`timescale 1ns / 1ps

module life_like_automaton_generation_top_tb;
  import lla_pkg::*;

  // Pacing patterns. The receiver reads the current pattern on every cycle and the sender
  // on every transaction, so gaps and stalls land on all phases of a transaction.
  typedef enum int {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_A_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         func_i;
  logic [5:0]         column_i;
  logic [5:0]         row_i;
  logic               cell_in_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               cell_value_o;
  logic [GEN_W-1:0]   generation_count_o;

  int    mismatch_total;
  int    results_pending;
  pace_e pace = PACE_FREE;

  // Area in use as the block sees it; only used to aim coordinates into the grid.
  int area_cols = MAX_COLUMNS;
  int area_rows = MAX_ROWS;
  int op_count [4];
  int settings_count;

  always #5 clk_i = ~clk_i;

  life_like_automaton_generation_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .column_i           (column_i),
    .row_i              (row_i),
    .cell_in_i          (cell_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .cell_value_o       (cell_value_o),
    .generation_count_o (generation_count_o)
  );

  life_like_automaton_generation_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .func_i             (func_i),
    .column_i           (column_i),
    .row_i              (row_i),
    .cell_in_i          (cell_in_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .cell_value_i       (cell_value_o),
    .generation_count_i (generation_count_o),
    .mismatch_count_o   (mismatch_total),
    .pending_count_o    (results_pending)
  );

  // The receiver stalls at random in the stall patterns and takes every result otherwise.
  always @(posedge clk_i) begin
    case (pace)
      PACE_RECV_STALL: out_ready_i <= ($urandom_range(99) >= 72);
      PACE_BOTH:       out_ready_i <= ($urandom_range(99) >= 19);
      default:         out_ready_i <= 1'b1;
    endcase
  end

  // Sends one transaction. Valid is only lowered when the sender decides to idle, so a
  // back-to-back transaction keeps valid high and just changes the payload at the edge.
  task automatic send_cell_op(func_e op, logic [5:0] col, logic [5:0] row, logic value);
    int idle_pct;
    idle_pct = (pace == PACE_SEND_IDLE) ? 72 : (pace == PACE_BOTH) ? 19 : 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    column_i   <= col;
    row_i      <= row;
    cell_in_i  <= value;
    do @(posedge clk_i); while (!in_ready_o);
    op_count[op]++;
  endtask

  // Drops valid and waits until the checker holds no more expected results. Every
  // transaction gives exactly one result, so the block is idle once this returns.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  // Writes all four registers back to back while the block is idle.
  task automatic apply_settings(logic [CNT_W-1:0] cols, logic [CNT_W-1:0] rows,
                                logic [MASK_W-1:0] birth, logic [MASK_W-1:0] survive);
    logic [CFG_A_W-1:0] reg_index [4];
    logic [CFG_W-1:0]   reg_value [4];
    reg_index = '{CFG_COLUMN_COUNT, CFG_ROW_COUNT, CFG_BIRTH_MASK, CFG_SURVIVE_MASK};
    reg_value = '{CFG_W'(cols), CFG_W'(rows), birth, survive};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_index[i];
      cfg_data_i  <= reg_value[i];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    area_cols = (cols == '0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
    area_rows = (rows == '0) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : int'(rows);
    settings_count++;
  endtask

  // Grid sizes lean small so that advances stay short; zero and values above the
  // maximum show up now and then, and so does the full width.
  function automatic logic [CNT_W-1:0] pick_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return CNT_W'($urandom_range(127, 65));
    if (pick < 30) return CNT_W'(MAX_COLUMNS);
    return CNT_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return MASK_W'($urandom_range(511));
  endfunction

  // Random transactions mostly build a pattern inside the area in use, advance it and
  // read it back; a share goes anywhere on the full coordinate range, so writes and
  // reads outside the area are exercised too.
  task automatic send_random_op();
    int         pick;
    func_e      op;
    logic [5:0] col;
    logic [5:0] row;
    pick = $urandom_range(99);
    op = (pick < 45) ? FUNC_WRITE : (pick < 58) ? FUNC_ADVANCE :
         (pick < 95) ? FUNC_READ : FUNC_NONE;
    if ($urandom_range(99) < 85) begin
      col = 6'($urandom_range(area_cols - 1));
      row = 6'($urandom_range(area_rows - 1));
    end else begin
      col = 6'($urandom_range(63));
      row = 6'($urandom_range(63));
    end
    send_cell_op(op, col, row, $urandom_range(99) < 70);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_COLUMN_COUNT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_WRITE;
    column_i    = '0;
    row_i       = '0;
    cell_in_i   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset settings: a 64 x 64 grid under B3/S23.
    // The four corner cells form a block through the wrap-around, which is a still life.
    send_cell_op(FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_cell_op(FUNC_WRITE, 6'd63, 6'd0, 1'b1);
    send_cell_op(FUNC_WRITE, 6'd0, 6'd63, 1'b1);
    send_cell_op(FUNC_WRITE, 6'd63, 6'd63, 1'b1);
    // A cell is written alive and then killed again.
    send_cell_op(FUNC_WRITE, 6'd20, 6'd5, 1'b1);
    send_cell_op(FUNC_WRITE, 6'd20, 6'd5, 1'b0);
    send_cell_op(FUNC_READ, 6'd20, 6'd5, 1'b0);
    send_cell_op(FUNC_READ, 6'd63, 6'd63, 1'b1);
    // The unused function code changes nothing, whatever its other fields hold.
    send_cell_op(FUNC_NONE, 6'd63, 6'd63, 1'b1);
    send_cell_op(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_cell_op(FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cell_op(FUNC_READ, 6'd1, 6'd1, 1'b0);

    // A two-column, one-row grid (a row count of zero acts as one) with every birth
    // and no survival: neighbor positions fold onto the same cells, the cell itself too.
    apply_settings(CNT_W'(2), '0, '1, '0);
    send_cell_op(FUNC_WRITE, 6'd1, 6'd0, 1'b1);
    // Writes outside the area in use are dropped and reads there give zero.
    send_cell_op(FUNC_WRITE, 6'd5, 6'd0, 1'b1);
    send_cell_op(FUNC_READ, 6'd5, 6'd0, 1'b0);
    send_cell_op(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_cell_op(FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cell_op(FUNC_READ, 6'd1, 6'd0, 1'b0);

    // Column count above the maximum saturates; two rows, no birth, every survival.
    // The corner at column 63 kept its value while it was outside the narrow area.
    apply_settings('1, CNT_W'(2), '0, '1);
    send_cell_op(FUNC_READ, 6'd63, 6'd0, 1'b0);
    send_cell_op(FUNC_READ, 6'd0, 6'd63, 1'b0);
    send_cell_op(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0);
    send_cell_op(FUNC_READ, 6'd63, 6'd1, 1'b0);
    send_cell_op(FUNC_WRITE, 6'd0, 6'd63, 1'b0);

    // Growing back to the full grid makes the untouched lower corner visible again.
    apply_settings(CNT_W'(MAX_COLUMNS), CNT_W'(MAX_ROWS), MASK_W'(8), MASK_W'(12));
    send_cell_op(FUNC_READ, 6'd0, 6'd63, 1'b0);
    send_cell_op(FUNC_ADVANCE, 6'd0, 6'd0, 1'b0);

    // Random part: eight settings, cycling through the four pacing patterns. The first phase
    // runs on a single cell, whose eight neighbor positions are all the cell itself.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) apply_settings(CNT_W'(1), CNT_W'(1), pick_mask(), pick_mask());
      else apply_settings(pick_count(), pick_count(), pick_mask(), pick_mask());
      pace = pace_e'(phase % 4);
      for (int k = 0; k < 15; k++) begin
        // Once, the sender holds off mid-phase until the block has handed back everything.
        if (phase == 5 && k == 9) wait_drained();
        send_random_op();
      end
    end

    // Let any stray result show up after the last expected one.
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d writes, %0d advances, %0d reads and %0d unused-code transactions",
             op_count[FUNC_WRITE], op_count[FUNC_ADVANCE], op_count[FUNC_READ],
             op_count[FUNC_NONE]);
    $display("over %0d register settings, grids from one cell to 64 x 64, four pacing patterns",
             settings_count);
    if (mismatch_total == 0) begin
      $display("[life_like_automaton_generation_top] OK");
    end else begin
      $display("%0d mismatches in total", mismatch_total);
      $display("[life_like_automaton_generation_top] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond a run in which every transaction is a full-grid advance
  // under the heaviest pacing.
  initial begin
    #30_000_000;
    $display("Timeout with %0d results still pending", results_pending);
    $display("[life_like_automaton_generation_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lla_pkg.sv
rtl/core/lla_grid.sv
rtl/core/lla_rule.sv
rtl/core/life_like_automaton_generation_top.sv
tb/sv/life_like_automaton_generation_checker.sv
tb/sv/life_like_automaton_generation_top_tb.sv
